### rtl/sync_frame_receiver_assert.svh
// ----------------------------------------------------------------------------
// sync frame receiver assertion macros
// clocked assertion helpers used by the receiver controller rtl
// ----------------------------------------------------------------------------
`ifndef SYNC_FRAME_RECEIVER_ASSERT_SVH
`define SYNC_FRAME_RECEIVER_ASSERT_SVH

// same-cycle implication, masked during reset
`define SFR_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, masked during reset
`define SFR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/sfr_pkg.sv
// ----------------------------------------------------------------------------
// sfr_pkg
// shared types and constants of the sync frame receiver
// ----------------------------------------------------------------------------
package sfr_pkg;

  localparam int unsigned FRAME_BYTES_DEF = 24;
  localparam int unsigned IDX_BITS        = 5;

  localparam logic [7:0]  HDR_FIRST     = 8'hAA;
  localparam logic [7:0]  HDR_SECOND    = 8'h55;
  localparam logic [15:0] TIMEOUT_RESET = 16'd50;

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  typedef struct packed {
    logic       op;
    logic [7:0] rx_byte;
  } item_t;

  typedef struct packed {
    logic [7:0]          payload_byte;
    logic [IDX_BITS-1:0] byte_index;
    logic                last;
  } result_t;

  // controller to shift chain and output side
  typedef struct packed {
    logic                shift;
    logic                valid;
    logic                last;
    logic [IDX_BITS-1:0] byte_index;
  } chain_ctrl_t;

endpackage

### rtl/sfr_cell.sv
// ----------------------------------------------------------------------------
// sfr_cell
// one byte cell of the payload shift chain
// ----------------------------------------------------------------------------
module sfr_cell (
  input  logic       clk,
  input  logic       shift,
  input  logic [7:0] d,
  output logic [7:0] q
);

  always_ff @(posedge clk) begin
    if (shift) begin
      q <= d;
    end
  end

endmodule

### rtl/sfr_ctrl.sv
// ----------------------------------------------------------------------------
// sfr_ctrl
// header hunt, payload fill, checksum check, idle timeout and burst sequencing
// ----------------------------------------------------------------------------
`include "sync_frame_receiver_assert.svh"

module sfr_ctrl #(
  parameter int unsigned FrameBytes = sfr_pkg::FRAME_BYTES_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_stall,
  input  sfr_pkg::item_t      item,
  input  logic                cfg_we,
  input  logic [15:0]         cfg_wdata,
  input  logic                result_stall,
  output sfr_pkg::chain_ctrl_t ctl
);
  import sfr_pkg::*;

  localparam int unsigned CntW = $clog2(FrameBytes + 1);
  localparam int unsigned ExtW = (CntW > IDX_BITS) ? CntW : IDX_BITS;

  typedef enum logic [4:0] {
    ST_HUNT_A = 5'b00001,
    ST_HUNT_B = 5'b00010,
    ST_FILL   = 5'b00100,
    ST_CHECK  = 5'b01000,
    ST_BURST  = 5'b10000
  } state_t;

  state_t          state, state_next;
  logic [CntW-1:0] fill, fill_next, fill_inc;
  logic [CntW-1:0] idx, idx_next;
  logic [7:0]      xor_acc, xor_acc_next;
  logic [15:0]     idle, idle_next, idle_inc;
  logic [15:0]     timeout;
  logic [ExtW-1:0] idx_ext;
  logic            accept;
  logic            out_fire;
  logic            idx_last;

  assign item_stall = (state == ST_BURST);
  assign accept     = item_valid && !item_stall;
  assign out_fire   = (state == ST_BURST) && !result_stall;
  assign idx_last   = (idx == CntW'(FrameBytes - 1));
  assign fill_inc   = fill + 1'b1;
  assign idle_inc   = (idle == 16'hFFFF) ? idle : idle + 16'd1;

  always_comb begin
    state_next   = state;
    fill_next    = fill;
    idx_next     = idx;
    xor_acc_next = xor_acc;
    idle_next    = idle;
    if (accept && item.op == OP_TICK) begin
      if (state != ST_HUNT_A) begin
        idle_next = idle_inc;
        if (idle_inc > timeout) begin
          state_next = ST_HUNT_A;
          fill_next  = '0;
        end
      end
    end else if (accept) begin
      idle_next = '0;
      case (state)
        ST_HUNT_A: begin
          if (item.rx_byte == HDR_FIRST) begin
            state_next = ST_HUNT_B;
          end
        end
        ST_HUNT_B: begin
          if (item.rx_byte == HDR_SECOND) begin
            state_next   = ST_FILL;
            fill_next    = '0;
            xor_acc_next = '0;
          end else begin
            state_next = ST_HUNT_A;
          end
        end
        ST_FILL: begin
          fill_next = fill_inc;
          // the final payload byte is stored but kept out of the checksum
          if (fill_inc < CntW'(FrameBytes)) begin
            xor_acc_next = xor_acc ^ item.rx_byte;
          end else begin
            state_next = ST_CHECK;
          end
        end
        ST_CHECK: begin
          fill_next = '0;
          if (item.rx_byte == xor_acc) begin
            state_next = ST_BURST;
            idx_next   = '0;
          end else begin
            state_next = ST_HUNT_A;
          end
        end
        default: begin
          state_next = ST_HUNT_A;
        end
      endcase
    end else if (out_fire) begin
      idx_next = idx + 1'b1;
      if (idx_last) begin
        state_next = ST_HUNT_A;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_HUNT_A;
      fill    <= '0;
      idx     <= '0;
      xor_acc <= '0;
      idle    <= '0;
      timeout <= TIMEOUT_RESET;
    end else begin
      state   <= state_next;
      fill    <= fill_next;
      idx     <= idx_next;
      xor_acc <= xor_acc_next;
      idle    <= idle_next;
      if (cfg_we) begin
        timeout <= cfg_wdata;
      end
    end
  end

  assign idx_ext = ExtW'(idx);

  always_comb begin
    ctl.shift      = (accept && item.op == OP_BYTE && state == ST_FILL) || out_fire;
    ctl.valid      = (state == ST_BURST);
    ctl.last       = idx_last;
    ctl.byte_index = idx_ext[IDX_BITS-1:0];
  end

  `SFR_ASSERT_NEXT(a_burst_needs_check, accept && state != ST_CHECK, state != ST_BURST, "burst without checksum byte")
  `SFR_ASSERT_NEXT(a_last_ends_burst, out_fire && idx_last, !ctl.valid, "burst continues past last item")
  `SFR_ASSERT_NEXT(a_idx_steps, out_fire && !idx_last, ctl.valid && idx == CntW'($past(idx) + 1'b1), "burst index did not advance")
  `SFR_ASSERT(a_fill_bound, state == ST_FILL, fill < CntW'(FrameBytes), "fill index past frame")

endmodule

### rtl/sync_frame_receiver.sv
// ----------------------------------------------------------------------------
// sync_frame_receiver
// deframer for 0xAA 0x55 headed frames with an xor checksum byte
// ----------------------------------------------------------------------------
// Takes one item (a link byte or a time tick) per clock while no burst is in
// flight. Payload bytes shift into a row of FRAME_BYTES byte cells; when the
// checksum byte matches, the frame leaves the head of that row as a burst of
// FRAME_BYTES results, one per cycle that the result side does not stall, and
// item intake stalls for the length of that burst. A frame is two header bytes,
// FRAME_BYTES payload bytes and the checksum byte (27 in all by default), and the
// burst leaves the single head cell of the shift chain. Ticks while a frame is
// open count toward the idle timeout held in the one configuration register (reset value 50).
module sync_frame_receiver #(
  parameter int unsigned FrameBytes = sfr_pkg::FRAME_BYTES_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_stall,
  input  sfr_pkg::item_t   item,
  output logic             result_valid,
  input  logic             result_stall,
  output sfr_pkg::result_t result,
  input  logic             cfg_we,
  input  logic [15:0]      cfg_wdata
);
  import sfr_pkg::*;

  chain_ctrl_t ctl;
  logic [7:0]  cell_q [FrameBytes];

  sfr_ctrl #(
    .FrameBytes (FrameBytes)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .result_stall (result_stall),
    .ctl          (ctl)
  );

  // bytes enter at the tail and move one cell toward the head per shift
  for (genvar i = 0; i < FrameBytes; i++) begin : g_cell
    logic [7:0] d;
    if (i == FrameBytes - 1) begin : g_tail
      assign d = item.rx_byte;
    end else begin : g_body
      assign d = cell_q[i+1];
    end
    sfr_cell u_cell (
      .clk   (clk),
      .shift (ctl.shift),
      .d     (d),
      .q     (cell_q[i])
    );
  end

  assign result_valid = ctl.valid;

  always_comb begin
    result.payload_byte = cell_q[0];
    result.byte_index   = ctl.byte_index;
    result.last         = ctl.last;
  end

endmodule
